>>> rtl/qid_pkg.sv
// Shared types, constants and the colour hash for the QOI chunk decoder.
package qid_pkg;

	localparam int CACHE_ENTRIES = 64;
	localparam int CACHE_AW      = $clog2(CACHE_ENTRIES);
	localparam int APB_AW        = 2;
	localparam int COUNT_W       = 7;

	localparam logic [APB_AW-1:0] REG_PIXEL_COUNT = 2'd0;

	localparam logic [31:0] PIXEL_COUNT_RESET = 32'd1;
	// a in 31:24, b in 23:16, g in 15:8, r in 7:0
	localparam logic [31:0] PREV_RESET        = 32'hFF00_0000;

	localparam logic [7:0] TAG_RGB  = 8'hFE;
	localparam logic [7:0] TAG_RGBA = 8'hFF;

	localparam logic [1:0] OPC_INDEX = 2'b00;
	localparam logic [1:0] OPC_DIFF  = 2'b01;
	localparam logic [1:0] OPC_LUMA  = 2'b10;
	localparam logic [1:0] OPC_RUN   = 2'b11;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_RGB,
		OP_RGBA,
		OP_LUMA
	} pend_op_t;

	typedef enum logic [1:0] {
		ST_TAG,
		ST_READ,
		ST_EMIT
	} dec_state_t;

	typedef struct packed {
		logic        wr;
		logic [31:0] value;
	} cfg_wr_t;

	typedef struct packed {
		logic                en;
		logic [CACHE_AW-1:0] addr;
	} cache_rd_t;

	typedef struct packed {
		logic                en;
		logic [CACHE_AW-1:0] addr;
		logic [31:0]         data;
	} cache_wr_t;

	// (r*3 + g*5 + b*7 + a*11) mod 64; only the low bits matter
	function automatic logic [CACHE_AW-1:0] hash_slot(input logic [31:0] px);
		logic [7:0] h;
		h = px[7:0] * 8'd3 + px[15:8] * 8'd5 + px[23:16] * 8'd7 + px[31:24] * 8'd11;
		return h[CACHE_AW-1:0];
	endfunction

endpackage

>>> rtl/qid_stream_if.sv
// Valid/ready channel interfaces: chunk bytes in, decoded pixels out.
interface qid_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] chunk_byte;

	modport source (output valid, output chunk_byte, input ready);
	modport sink   (input valid, input chunk_byte, output ready);
endinterface

interface qid_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha;
	logic       last_of_run;
	logic       image_done;

	modport source (output valid, output red, output green, output blue, output alpha,
		output last_of_run, output image_done, input ready);
	modport sink   (input valid, input red, input green, input blue, input alpha,
		input last_of_run, input image_done, output ready);
endinterface

>>> rtl/qid_cache.sv
// 64-entry colour cache: synchronous RAM plus per-entry valid bits (invalid reads zero).
module qid_cache (
	input  logic                          clk,
	input  logic                          arst_n,
	input  qid_pkg::cache_rd_t            rd,
	output logic [31:0]                   rd_data,
	input  qid_pkg::cache_wr_t            wr
);

	logic [31:0]                      mem [qid_pkg::CACHE_ENTRIES];
	logic [qid_pkg::CACHE_ENTRIES-1:0] valid_q;
	logic [31:0]                      rdata_q;
	logic                             rvalid_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rdata_q <= mem[rd.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			if (rd.en) begin
				rvalid_q <= valid_q[rd.addr];
			end
		end
	end

	assign rd_data = rvalid_q ? rdata_q : 32'd0;

endmodule

>>> rtl/qid_decode.sv
// Chunk parser, pixel state and run emitter with the output register.
module qid_decode (
	input  logic                 clk,
	input  logic                 arst_n,
	qid_byte_if.sink             chunk_in,
	qid_pixel_if.source          pixel_out,
	input  qid_pkg::cfg_wr_t     cfg,
	output qid_pkg::cache_rd_t   cache_rd,
	input  logic [31:0]          cache_rdata,
	output qid_pkg::cache_wr_t   cache_wr
);

	qid_pkg::dec_state_t state_q, state_d;
	qid_pkg::pend_op_t   pend_q, pend_d;
	logic [2:0]                   need_q, need_d;
	logic [31:0]                  part_q, part_d;
	logic [5:0]                   luma_q, luma_d;
	logic [31:0]                  left_q, left_d;
	logic [qid_pkg::COUNT_W-1:0]  count_q, count_d;
	logic [31:0]                  prev_q, prev_d;

	logic        out_valid_q, out_valid_d;
	logic [31:0] out_pix_q;
	logic        out_last_q, out_done_q;

	logic [7:0]  byte_in;
	logic [31:0] part_next;
	logic [31:0] lit_pix;
	logic [31:0] diff_pix;
	logic [7:0]  vg;
	logic        slot_free;
	logic        out_load;
	logic        is_last;

	assign byte_in   = chunk_in.chunk_byte;
	assign part_next = {part_q[23:0], byte_in};
	assign slot_free = !out_valid_q || pixel_out.ready;
	assign is_last   = (count_q == qid_pkg::COUNT_W'(1)) || (left_q == 32'd1);

	// completed multi-byte op, selected by the op that is pending
	always_comb begin
		vg = {2'b00, luma_q} - 8'd32;
		case (pend_q)
			qid_pkg::OP_RGB:  lit_pix = {prev_q[31:24], part_next[7:0], part_next[15:8],
				part_next[23:16]};
			qid_pkg::OP_RGBA: lit_pix = {part_next[7:0], part_next[15:8], part_next[23:16],
				part_next[31:24]};
			qid_pkg::OP_LUMA: lit_pix = {prev_q[31:24],
				prev_q[23:16] + vg - 8'd8 + {4'd0, byte_in[3:0]},
				prev_q[15:8] + vg,
				prev_q[7:0] + vg - 8'd8 + {4'd0, byte_in[7:4]}};
			default:          lit_pix = prev_q;
		endcase
	end

	assign diff_pix = {prev_q[31:24],
		prev_q[23:16] + {6'd0, byte_in[1:0]} - 8'd2,
		prev_q[15:8] + {6'd0, byte_in[3:2]} - 8'd2,
		prev_q[7:0] + {6'd0, byte_in[5:4]} - 8'd2};

	always_comb begin
		state_d  = state_q;
		pend_d   = pend_q;
		need_d   = need_q;
		part_d   = part_q;
		luma_d   = luma_q;
		left_d   = left_q;
		count_d  = count_q;
		prev_d   = prev_q;
		out_load = 1'b0;
		cache_rd = '{en: 1'b0, addr: byte_in[qid_pkg::CACHE_AW-1:0]};
		cache_wr = '{en: 1'b0, addr: qid_pkg::hash_slot(prev_q), data: prev_q};
		chunk_in.ready = (state_q == qid_pkg::ST_TAG);

		case (state_q)
			qid_pkg::ST_TAG: begin
				if (chunk_in.valid && left_q != 32'd0) begin
					if (pend_q != qid_pkg::OP_NONE) begin
						part_d = part_next;
						if (need_q > 3'd1) begin
							need_d = need_q - 3'd1;
						end else begin
							need_d  = 3'd0;
							pend_d  = qid_pkg::OP_NONE;
							prev_d  = lit_pix;
							count_d = qid_pkg::COUNT_W'(1);
							state_d = qid_pkg::ST_EMIT;
						end
					end else if (byte_in == qid_pkg::TAG_RGB) begin
						pend_d = qid_pkg::OP_RGB;
						need_d = 3'd3;
						part_d = 32'd0;
					end else if (byte_in == qid_pkg::TAG_RGBA) begin
						pend_d = qid_pkg::OP_RGBA;
						need_d = 3'd4;
						part_d = 32'd0;
					end else begin
						case (byte_in[7:6])
							qid_pkg::OPC_INDEX: begin
								cache_rd.en = 1'b1;
								count_d     = qid_pkg::COUNT_W'(1);
								state_d     = qid_pkg::ST_READ;
							end
							qid_pkg::OPC_DIFF: begin
								prev_d  = diff_pix;
								count_d = qid_pkg::COUNT_W'(1);
								state_d = qid_pkg::ST_EMIT;
							end
							qid_pkg::OPC_LUMA: begin
								luma_d = byte_in[5:0];
								pend_d = qid_pkg::OP_LUMA;
								need_d = 3'd1;
								part_d = 32'd0;
							end
							qid_pkg::OPC_RUN: begin
								count_d = {1'b0, byte_in[5:0]} + qid_pkg::COUNT_W'(1);
								state_d = qid_pkg::ST_EMIT;
							end
							default: begin
								state_d = qid_pkg::ST_TAG;
							end
						endcase
					end
				end
			end
			qid_pkg::ST_READ: begin
				prev_d  = cache_rdata;
				state_d = qid_pkg::ST_EMIT;
			end
			qid_pkg::ST_EMIT: begin
				// rewrite every emit cycle: same slot, same value
				cache_wr.en = 1'b1;
				if (slot_free) begin
					out_load = 1'b1;
					left_d   = left_q - 32'd1;
					count_d  = count_q - qid_pkg::COUNT_W'(1);
					if (is_last) begin
						state_d = qid_pkg::ST_TAG;
					end
				end
			end
			default: begin
				state_d = qid_pkg::ST_TAG;
			end
		endcase

		if (cfg.wr) begin
			left_d = cfg.value;
		end

		if (out_load) begin
			out_valid_d = 1'b1;
		end else if (pixel_out.ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= qid_pkg::ST_TAG;
			pend_q      <= qid_pkg::OP_NONE;
			need_q      <= 3'd0;
			part_q      <= 32'd0;
			luma_q      <= 6'd0;
			left_q      <= qid_pkg::PIXEL_COUNT_RESET;
			count_q     <= '0;
			prev_q      <= qid_pkg::PREV_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			pend_q      <= pend_d;
			need_q      <= need_d;
			part_q      <= part_d;
			luma_q      <= luma_d;
			left_q      <= left_d;
			count_q     <= count_d;
			prev_q      <= prev_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_pix_q  <= prev_q;
			out_last_q <= is_last;
			out_done_q <= (left_q == 32'd1);
		end
	end

	assign pixel_out.valid       = out_valid_q;
	assign pixel_out.red         = out_pix_q[7:0];
	assign pixel_out.green       = out_pix_q[15:8];
	assign pixel_out.blue        = out_pix_q[23:16];
	assign pixel_out.alpha       = out_pix_q[31:24];
	assign pixel_out.last_of_run = out_last_q;
	assign pixel_out.image_done  = out_done_q;

endmodule

>>> rtl/qoi_image_decoder_top.sv
// Top level of the QOI chunk-stream decoder: APB register, parser and colour cache.
//
//  channel     dir  handshake            word
//  chunk_in    in   valid/ready          chunk_byte[7:0]
//  pixel_out   out  valid/ready          red, green, blue, alpha, last_of_run, image_done
//  apb         in   psel/penable/pready  pixel_count at byte address 0
//
// Tag and operand bytes that complete no pixel are taken in ST_TAG. A byte that
// completes a pixel moves to ST_EMIT, which sends the pixel or the whole run
// in turn; INDEX passes through ST_READ first for the cache read port.
// Reset clears the cache valid bits at once, so no clearing pass is needed.
// A stalled output holds the emitter; the input is taken only in ST_TAG, not while pixels are read or emitted.
module qoi_image_decoder_top (
	input  logic                         clk,
	input  logic                         arst_n,
	qid_byte_if.sink                     chunk_in,
	qid_pixel_if.source                  pixel_out,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [qid_pkg::APB_AW-1:0]   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	logic [31:0]         pixel_count_q;
	qid_pkg::cfg_wr_t    cfg;
	qid_pkg::cache_rd_t  cache_rd;
	qid_pkg::cache_wr_t  cache_wr;
	logic [31:0]         cache_rdata;

	// writes complete in the access phase, no wait states
	assign pready = 1'b1;
	assign cfg.wr = psel && penable && pwrite && (paddr == qid_pkg::REG_PIXEL_COUNT);
	assign cfg.value = pwdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_count_q <= qid_pkg::PIXEL_COUNT_RESET;
		end else if (cfg.wr) begin
			pixel_count_q <= pwdata;
		end
	end

	assign prdata = (paddr == qid_pkg::REG_PIXEL_COUNT) ? pixel_count_q : 32'd0;

	qid_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.chunk_in    (chunk_in),
		.pixel_out   (pixel_out),
		.cfg         (cfg),
		.cache_rd    (cache_rd),
		.cache_rdata (cache_rdata),
		.cache_wr    (cache_wr)
	);

	qid_cache u_cache (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd      (cache_rd),
		.rd_data (cache_rdata),
		.wr      (cache_wr)
	);

`ifndef SYNTH
	// the final pixel of the image always closes its run
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_out.valid && pixel_out.image_done |-> pixel_out.last_of_run)
		else $error("image_done without last_of_run");

	// nothing follows the final pixel
	a_quiet_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_out.valid && pixel_out.ready && pixel_out.image_done |=> !pixel_out.valid)
		else $error("pixel emitted after image_done");

	// cache never read and written in the same cycle
	a_cache_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(cache_rd.en && cache_wr.en))
		else $error("cache read and write overlap");
`endif

endmodule

>>> tb/qoi_image_decoder_top_tb.sv
// Self-checking testbench for the QOI chunk decoder: random byte streams against a pixel predictor.
`timescale 1ns / 100ps

module qoi_image_decoder_top_tb;

	localparam int SETTLE       = 16;   // cycles a no-pixel byte may still be in flight
	localparam int LONG_HOLD    = 500;  // receiver hold-off that backs the decoder up
	localparam int RANDOM_WORDS = 320;
	localparam int SHOW_LIMIT   = 10;

	// one decoded pixel as it leaves the block
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       last_of_run;
		logic       image_done;
	} pixel_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [qid_pkg::APB_AW-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	qid_byte_if  chunk_if ();
	qid_pixel_if pixel_if ();

	qoi_image_decoder_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.chunk_in  (chunk_if),
		.pixel_out (pixel_if),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------------
	// Predictor state: our own copy of the decoder's view of the stream.
	// Colours are packed a:b:g:r, red in the low byte.
	// ---------------------------------------------------------------------
	logic [31:0]       last_colour;
	logic [31:0]       seen_colours [qid_pkg::CACHE_ENTRIES];
	qid_pkg::pend_op_t waiting_op;
	int unsigned       operand_count;
	logic [31:0]       operand_bits;
	logic [5:0]        luma_green;
	logic [31:0]       pixels_to_go;

	pixel_t      pixels_due_q [$];  // decoded pixels not yet seen at the output
	logic [7:0]  chunk_bytes_q [$]; // bytes waiting for the driver

	int mismatches;
	int holds_asked, holds_done;

	task automatic note_failure(input string what);
		mismatches++;
		if (mismatches <= SHOW_LIMIT)
			$display("%0t: %s", $realtime, what);
	endtask

	function automatic logic [qid_pkg::CACHE_AW-1:0] colour_slot(input logic [31:0] c);
		int sum;
		sum = c[7:0] * 3 + c[15:8] * 5 + c[23:16] * 7 + c[31:24] * 11;
		return qid_pkg::CACHE_AW'(sum % qid_pkg::CACHE_ENTRIES);
	endfunction

	// Works out the pixels that one accepted chunk byte gives; appends them to pixels_due_q.
	function automatic void decode_chunk_byte(input logic [7:0] cb);
		logic [7:0]  r, g, b, a, dg;
		int unsigned n;
		if (pixels_to_go == 0)
			return; // image complete, byte dropped
		r = last_colour[7:0];
		g = last_colour[15:8];
		b = last_colour[23:16];
		a = last_colour[31:24];
		n = 0;
		if (waiting_op != qid_pkg::OP_NONE) begin
			operand_bits = {operand_bits[23:0], cb};
			if (operand_count > 1) begin
				operand_count--;
				return;
			end
			operand_count = 0;
			case (waiting_op)
				qid_pkg::OP_RGB: begin
					r = operand_bits[23:16];
					g = operand_bits[15:8];
					b = operand_bits[7:0];
				end
				qid_pkg::OP_RGBA: begin
					r = operand_bits[31:24];
					g = operand_bits[23:16];
					b = operand_bits[15:8];
					a = operand_bits[7:0];
				end
				default: begin
					// green delta biased by 32, red/blue relative to it biased by 8
					dg = {2'b00, luma_green} - 8'd32;
					r  = r + dg - 8'd8 + {4'b0000, cb[7:4]};
					g  = g + dg;
					b  = b + dg - 8'd8 + {4'b0000, cb[3:0]};
				end
			endcase
			waiting_op  = qid_pkg::OP_NONE;
			last_colour = {a, b, g, r};
			n = 1;
		end else if (cb == qid_pkg::TAG_RGB || cb == qid_pkg::TAG_RGBA) begin
			waiting_op    = (cb == qid_pkg::TAG_RGB) ? qid_pkg::OP_RGB : qid_pkg::OP_RGBA;
			operand_count = (cb == qid_pkg::TAG_RGB) ? 3 : 4;
			operand_bits  = '0;
			return;
		end else begin
			case (cb[7:6])
				qid_pkg::OPC_INDEX: begin
					last_colour = seen_colours[cb[5:0]];
					n = 1;
				end
				qid_pkg::OPC_DIFF: begin
					r = r + {6'd0, cb[5:4]} - 8'd2;
					g = g + {6'd0, cb[3:2]} - 8'd2;
					b = b + {6'd0, cb[1:0]} - 8'd2;
					last_colour = {a, b, g, r};
					n = 1;
				end
				qid_pkg::OPC_LUMA: begin
					luma_green    = cb[5:0];
					waiting_op    = qid_pkg::OP_LUMA;
					operand_count = 1;
					operand_bits  = '0;
					return;
				end
				default: n = cb[5:0] + 1; // run of the previous colour
			endcase
		end
		seen_colours[colour_slot(last_colour)] = last_colour;
		// a run longer than what is left of the image is cut short
		if (n > pixels_to_go)
			n = pixels_to_go;
		for (int unsigned k = 0; k < n; k++) begin
			pixels_to_go--;
			pixels_due_q.push_back('{red: last_colour[7:0], green: last_colour[15:8],
				blue: last_colour[23:16], alpha: last_colour[31:24],
				last_of_run: (k + 1 == n), image_done: (pixels_to_go == 0)});
		end
	endfunction

	// Gap length for either side: mostly none, sometimes short, now and then long,
	// with calm stretches where nothing idles at all.
	function automatic int next_gap(inout int calm);
		int pick;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		pick = $urandom_range(0, 99);
		if (pick < 3) begin
			calm = $urandom_range(30, 120);
			return 0;
		end
		if (pick < 65)
			return 0;
		if (pick < 88)
			return $urandom_range(1, 3);
		if (pick < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// ---------------------------------------------------------------------
	// Byte driver: offers the next queued byte, with random gaps between words.
	// ---------------------------------------------------------------------
	int in_gap, in_calm;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_if.valid      <= 1'b0;
			chunk_if.chunk_byte <= '0;
			in_gap  = 0;
			in_calm = 0;
		end else if (!chunk_if.valid || chunk_if.ready) begin
			if (in_gap > 0) begin
				in_gap--;
				chunk_if.valid <= 1'b0;
			end else if (chunk_bytes_q.size() > 0) begin
				chunk_if.valid      <= 1'b1;
				chunk_if.chunk_byte <= chunk_bytes_q.pop_front();
				in_gap = next_gap(in_calm);
			end else begin
				chunk_if.valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Pixel receiver: random back-pressure, plus a long hold-off on request
	// so the decoder fills up and stops taking bytes.
	// ---------------------------------------------------------------------
	int out_gap, out_calm, hold_cycles;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_if.ready <= 1'b0;
			out_gap     = 0;
			out_calm    = 0;
			hold_cycles = 0;
		end else begin
			if (holds_done < holds_asked) begin
				holds_done++;
				hold_cycles = LONG_HOLD;
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				pixel_if.ready <= 1'b0;
			end else if (out_gap > 0) begin
				out_gap--;
				pixel_if.ready <= 1'b0;
			end else begin
				pixel_if.ready <= 1'b1;
				out_gap = next_gap(out_calm);
			end
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: predicts on each accepted byte first, then checks any pixel
	// taken at the same edge against the oldest expectation.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin : watch_ports
		pixel_t want, got;
		if (arst_n) begin
			if (chunk_if.valid && chunk_if.ready)
				decode_chunk_byte(chunk_if.chunk_byte);
			if (pixel_if.valid && pixel_if.ready) begin
				got = '{red: pixel_if.red, green: pixel_if.green, blue: pixel_if.blue,
					alpha: pixel_if.alpha, last_of_run: pixel_if.last_of_run,
					image_done: pixel_if.image_done};
				if (pixels_due_q.size() == 0) begin
					note_failure($sformatf("unexpected pixel r%h g%h b%h a%h last %b done %b",
						got.red, got.green, got.blue, got.alpha,
						got.last_of_run, got.image_done));
				end else begin
					want = pixels_due_q.pop_front();
					if (got.red !== want.red || got.green !== want.green ||
						got.blue !== want.blue || got.alpha !== want.alpha ||
						got.last_of_run !== want.last_of_run ||
						got.image_done !== want.image_done)
						note_failure($sformatf({"pixel mismatch: want r%h g%h b%h a%h last %b ",
							"done %b, got r%h g%h b%h a%h last %b done %b"},
							want.red, want.green, want.blue, want.alpha,
							want.last_of_run, want.image_done,
							got.red, got.green, got.blue, got.alpha,
							got.last_of_run, got.image_done));
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Register access and stimulus helpers
	// ---------------------------------------------------------------------
	task automatic apb_xfer(input logic wr, input logic [31:0] wdata,
		output logic [31:0] rdata);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= qid_pkg::REG_PIXEL_COUNT;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Write pixel_count, mirror it in the predictor and read it back.
	// Only the remaining-pixel count is reloaded; colour, cache and half-read ops stay.
	task automatic set_pixel_count(input logic [31:0] value);
		logic [31:0] readback;
		apb_xfer(1'b1, value, readback);
		pixels_to_go = value;
		apb_xfer(1'b0, '0, readback);
		if (readback !== value)
			note_failure($sformatf("pixel_count reads %h, wrote %h", readback, value));
	endtask

	// Sender pause: all bytes taken, every pixel seen, then a settling wait
	// for any byte still in the block that gives no pixel.
	task automatic wait_for_drain();
		while (chunk_bytes_q.size() != 0 || chunk_if.valid || pixels_due_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic push_bytes(input logic [7:0] seq [$]);
		foreach (seq[i])
			chunk_bytes_q.push_back(seq[i]);
	endtask

	// Stream trailer: seven zero bytes and a one; normally dropped as the image is done.
	task automatic push_end_marker();
		repeat (7) chunk_bytes_q.push_back({qid_pkg::OPC_INDEX, 6'd0});
		chunk_bytes_q.push_back({qid_pkg::OPC_INDEX, 6'd1});
	endtask

	// One random op, mostly well formed; a tenth are stray bytes that break the framing.
	function automatic void add_random_op(inout int unsigned pixels_made,
		inout int unsigned words_made);
		int pick;
		logic [5:0] run_len;
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			chunk_bytes_q.push_back({qid_pkg::OPC_INDEX, 6'($urandom_range(0, 63))});
			words_made  += 1;
			pixels_made += 1;
		end else if (pick < 40) begin
			chunk_bytes_q.push_back({qid_pkg::OPC_DIFF, 6'($urandom)});
			words_made  += 1;
			pixels_made += 1;
		end else if (pick < 60) begin
			chunk_bytes_q.push_back({qid_pkg::OPC_LUMA, 6'($urandom)});
			chunk_bytes_q.push_back(8'($urandom));
			words_made  += 2;
			pixels_made += 1;
		end else if (pick < 72) begin
			// short runs mostly; 61 is the longest legal run code
			run_len = ($urandom_range(0, 4) != 0) ? 6'($urandom_range(0, 7))
				: 6'($urandom_range(8, 61));
			chunk_bytes_q.push_back({qid_pkg::OPC_RUN, run_len});
			words_made  += 1;
			pixels_made += run_len + 1;
		end else if (pick < 82) begin
			chunk_bytes_q.push_back(qid_pkg::TAG_RGB);
			repeat (3) chunk_bytes_q.push_back(8'($urandom));
			words_made  += 4;
			pixels_made += 1;
		end else if (pick < 90) begin
			chunk_bytes_q.push_back(qid_pkg::TAG_RGBA);
			repeat (4) chunk_bytes_q.push_back(8'($urandom));
			words_made  += 5;
			pixels_made += 1;
		end else begin
			chunk_bytes_q.push_back(8'($urandom));
			words_made += 1;
		end
	endfunction

	// ---------------------------------------------------------------------
	// Test sequence
	// ---------------------------------------------------------------------
	initial begin
		logic [31:0] readback;
		logic [31:0] size;
		int unsigned target, pixels_made, words_made;
		int image_no;

		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		chunk_if.valid      = 1'b0;
		chunk_if.chunk_byte = '0;
		pixel_if.ready      = 1'b0;
		mismatches  = 0;
		holds_asked = 0;
		holds_done  = 0;

		last_colour = qid_pkg::PREV_RESET;
		foreach (seen_colours[i])
			seen_colours[i] = '0;
		waiting_op    = qid_pkg::OP_NONE;
		operand_count = 0;
		operand_bits  = '0;
		luma_green    = '0;
		pixels_to_go  = qid_pkg::PIXEL_COUNT_RESET;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset value of pixel_count is one: the longest run is cut to a single
		// pixel carrying both flags, and the trailer is dropped.
		apb_xfer(1'b0, '0, readback);
		if (readback !== qid_pkg::PIXEL_COUNT_RESET)
			note_failure($sformatf("pixel_count resets to %h", readback));
		push_bytes('{{qid_pkg::OPC_RUN, 6'd61}});
		push_end_marker();
		wait_for_drain();

		// Zero pixel count: decoder stays finished, every byte ignored.
		set_pixel_count(32'd0);
		push_bytes('{qid_pkg::TAG_RGB, qid_pkg::TAG_RGBA, {qid_pkg::OPC_DIFF, 6'd0},
			{qid_pkg::OPC_LUMA, 6'd5}, {qid_pkg::OPC_RUN, 6'd3}});
		wait_for_drain();

		// Effectively endless image: every op and its operand extremes.
		set_pixel_count(32'hFFFF_FFFF);
		push_bytes('{
			qid_pkg::TAG_RGB, 8'h00, 8'h00, 8'h00,
			qid_pkg::TAG_RGBA, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			qid_pkg::TAG_RGBA, 8'h00, 8'h00, 8'h00, 8'h00,
			{qid_pkg::OPC_DIFF, 6'b00_00_00}, {qid_pkg::OPC_DIFF, 6'b11_11_11},
			{qid_pkg::OPC_LUMA, 6'd0}, 8'h00,
			{qid_pkg::OPC_LUMA, 6'd63}, 8'hFF,
			{qid_pkg::OPC_INDEX, 6'd0}, {qid_pkg::OPC_INDEX, 6'd63},
			{qid_pkg::OPC_RUN, 6'd0}, {qid_pkg::OPC_RUN, 6'd61},
			qid_pkg::TAG_RGB, 8'h12});
		wait_for_drain();

		// Register write with an RGB op half received: the op completes after
		// the write, then a run overshoots the three-pixel image.
		set_pixel_count(32'd3);
		push_bytes('{8'h34, 8'h56, {qid_pkg::OPC_RUN, 6'd2}, {qid_pkg::OPC_DIFF, 6'd5}});
		push_end_marker();
		wait_for_drain();

		// Random images, each of mostly well-formed ops with stray bytes mixed in.
		words_made = 0;
		image_no   = 0;
		while (words_made < RANDOM_WORDS) begin
			if (image_no == 3) begin
				size   = {1'b1, 31'($urandom)};
				target = 100;
			end else begin
				size   = $urandom_range(8, 120);
				target = size;
			end
			set_pixel_count(size);
			if (image_no == 1)
				holds_asked++; // receiver holds off at the start of this image so the decoder backs up
			pixels_made = 0;
			while (pixels_made < target)
				add_random_op(pixels_made, words_made);
			push_end_marker();
			wait_for_drain();
			image_no++;
		end

		if (mismatches == 0 && pixels_due_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#500_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> sim.f
rtl/qid_pkg.sv
rtl/qid_stream_if.sv
rtl/qid_cache.sv
rtl/qid_decode.sv
rtl/qoi_image_decoder_top.sv
tb/qoi_image_decoder_top_tb.sv
